### rtl/core/frc_pkg.sv
// Shared types and constants for the framed response checker.
// No dependencies; every module of the block imports this package.
`default_nettype none

package frc_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 17;
	localparam int LEN_W   = 16;
	localparam int IDX_W   = 2;
	localparam int STAT_W  = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COUNT_W:0]   MIN_FRAME = (COUNT_W+1)'(6);

	// Byte positions inside a frame.
	localparam logic [COUNT_W-1:0] POS_START  = COUNT_W'(0);
	localparam logic [COUNT_W-1:0] POS_LEN_HI = COUNT_W'(2);
	localparam logic [COUNT_W-1:0] POS_LEN_LO = COUNT_W'(3);
	localparam logic [COUNT_W-1:0] POS_ACK    = COUNT_W'(4);

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_START = 2'd0;
	localparam logic [IDX_W-1:0] REG_END   = 2'd1;
	localparam logic [IDX_W-1:0] REG_ACK   = 2'd2;

	localparam logic [BYTE_W-1:0] START_RST = 8'd27;
	localparam logic [BYTE_W-1:0] END_RST   = 8'd13;
	localparam logic [BYTE_W-1:0] ACK_RST   = 8'd6;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FORMAT   = 2'd1;
	localparam logic [STAT_W-1:0] ST_CHECKSUM = 2'd2;
	localparam logic [STAT_W-1:0] ST_NACK     = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] start_marker;
		logic [BYTE_W-1:0] end_marker;
		logic [BYTE_W-1:0] ack_code;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [LEN_W-1:0]   len;
		logic [BYTE_W-1:0]  sum;
		logic [BYTE_W-1:0]  prev;
		logic               start_ok;
		logic               ack_ok;
	} frame_t;

endpackage

`default_nettype wire

### rtl/core/framed_response_checker.sv
// Top level of the framed response checker.
// Depends on frc_pkg, frc_cfg_regs, frc_tracker and frc_judge.
//
//   channel   signals                          direction  transaction
//   rx        rx_valid rx_ready rx_byte         in         one frame byte
//             frame_last
//   st        st_valid st_ready status          out        one status per frame
//   cfg       cfg_we cfg_idx cfg_data           in         register write
//
// A byte is taken each cycle that rx_ready is high; status appears the cycle after the last byte.
// The single status register sets the rate: rx_ready drops only while a status
// waits and st_ready is low. Reset loads the default markers and clears the frame.
`default_nettype none

module framed_response_checker
	import frc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rx_valid,
	output logic                   rx_ready,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic              frame_last,
	output logic                   st_valid,
	input  wire logic              st_ready,
	output logic [STAT_W-1:0]      status,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_idx,
	input  wire logic [BYTE_W-1:0] cfg_data
);

	cfg_t   cfg;
	frame_t frame;
	logic   take;

	assign rx_ready = !st_valid || st_ready;
	assign take     = rx_valid && rx_ready;

	frc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	frc_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (rx_byte),
		.frame_last (frame_last),
		.cfg        (cfg),
		.frame      (frame)
	);

	frc_judge u_judge (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (rx_byte),
		.frame_last (frame_last),
		.frame      (frame),
		.end_marker (cfg.end_marker),
		.st_ready   (st_ready),
		.st_valid   (st_valid),
		.status     (status)
	);

endmodule

`default_nettype wire

### rtl/core/frc_cfg_regs.sv
// Configuration registers of the framed response checker.
// Depends on frc_pkg.
`default_nettype none

module frc_cfg_regs
	import frc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_idx,
	input  wire logic [BYTE_W-1:0] cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker <= START_RST;
			cfg_q.end_marker   <= END_RST;
			cfg_q.ack_code     <= ACK_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_START: cfg_q.start_marker <= cfg_data;
				REG_END:   cfg_q.end_marker   <= cfg_data;
				REG_ACK:   cfg_q.ack_code     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/core/frc_tracker.sv
// Per-frame state: byte count, length field, running sum and marker flags.
// Depends on frc_pkg.
`default_nettype none

module frc_tracker
	import frc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic              frame_last,
	input  wire cfg_t              cfg,
	output frame_t                 frame
);

	frame_t frame_q;
	frame_t frame_nxt;

	always_comb begin
		frame_nxt = frame_q;
		if (frame_last) begin
			frame_nxt = '0;
		end else begin
			if (frame_q.count == POS_START) begin
				frame_nxt.start_ok = (rx_byte == cfg.start_marker);
			end else begin
				frame_nxt.sum = frame_q.sum + rx_byte;
			end
			if (frame_q.count == POS_LEN_HI) begin
				frame_nxt.len[LEN_W-1:BYTE_W] = rx_byte;
			end
			if (frame_q.count == POS_LEN_LO) begin
				frame_nxt.len[BYTE_W-1:0] = rx_byte;
			end
			if (frame_q.count == POS_ACK) begin
				frame_nxt.ack_ok = (rx_byte == cfg.ack_code);
			end
			frame_nxt.prev = rx_byte;
			if (frame_q.count != COUNT_MAX) begin
				frame_nxt.count = frame_q.count + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (take) begin
			frame_q <= frame_nxt;
		end
	end

	assign frame = frame_q;

	// A last byte always leaves a cleared frame behind.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && frame_last |=> frame_q.count == '0 && !frame_q.start_ok)
		else $error("frame state not cleared after last byte");

	// The count advances by one on an ordinary byte until it saturates.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && !frame_last && frame_q.count != COUNT_MAX
		|=> frame_q.count == $past(frame_q.count) + COUNT_W'(1))
		else $error("byte count did not advance");

endmodule

`default_nettype wire

### rtl/core/frc_judge.sv
// Frame verdict on the last byte and the status output register.
// Depends on frc_pkg.
`default_nettype none

module frc_judge
	import frc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic [BYTE_W-1:0]  rx_byte,
	input  wire logic               frame_last,
	input  wire frame_t             frame,
	input  wire logic [BYTE_W-1:0]  end_marker,
	input  wire logic               st_ready,
	output logic                    st_valid,
	output logic [STAT_W-1:0]       status
);

	logic [COUNT_W:0]  total;
	logic [COUNT_W:0]  expected;
	logic [BYTE_W-1:0] data_sum;
	logic [STAT_W-1:0] verdict;
	logic              valid_q;
	logic [STAT_W-1:0] status_q;

	always_comb begin
		total    = {1'b0, frame.count} + (COUNT_W+1)'(1);
		expected = MIN_FRAME + {{(COUNT_W+1-LEN_W){1'b0}}, frame.len};
		// The sum includes the checksum byte itself, which sits in prev.
		data_sum = frame.sum - frame.prev;
		if (total < MIN_FRAME || !frame.start_ok) begin
			verdict = ST_FORMAT;
		end else if (total != expected) begin
			verdict = ST_FORMAT;
		end else if (data_sum != frame.prev) begin
			verdict = ST_CHECKSUM;
		end else if (rx_byte != end_marker) begin
			verdict = ST_FORMAT;
		end else if (!frame.ack_ok) begin
			verdict = ST_NACK;
		end else begin
			verdict = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take && frame_last) begin
			valid_q <= 1'b1;
		end else if (st_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && frame_last) begin
			status_q <= verdict;
		end
	end

	assign st_valid = valid_q;
	assign status   = status_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take && frame_last |=> valid_q)
		else $error("no status after last byte");

	a_result_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && st_ready && !(take && frame_last) |=> !valid_q)
		else $error("status delivered twice");

endmodule

`default_nettype wire
